// ----- design/bbs_pkg.sv -----
// Shared types and constants for the Bollinger band signal block.
// No dependencies; every other file refers to this package by scoped names.
package bbs_pkg;

   localparam int PRICE_IN_W = 24;
   localparam int PRICE_W    = 25;   // half-tick price
   localparam int FQTY_W     = 32;
   localparam int FCOMM_W    = 32;
   localparam int OQTY_W     = 47;
   localparam int POS_W      = 48;
   localparam int CAP_W      = 64;
   localparam int CFG_W      = 62;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 64;
   localparam int DIV_N      = 63;   // dividend bits (positive capital)
   localparam int DIV_D      = 28;   // divisor bits (5 * price)

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_FILL  = 1'b1;
   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   typedef struct packed {
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             start;
      logic [DIV_N-1:0] dividend;
      logic [DIV_D-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_N-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- design/bbs_if.sv -----
// Valid/ready channel interfaces for requests, results and the capital register.
// Depends on bbs_pkg for field widths.
interface bbs_req_if;
   logic                            valid;
   logic                            ready;
   logic                            command;
   logic [bbs_pkg::PRICE_IN_W-1:0]  last_price;
   logic [bbs_pkg::PRICE_IN_W-1:0]  bid_price;
   logic [bbs_pkg::PRICE_IN_W-1:0]  ask_price;
   logic                            fill_side;
   logic [bbs_pkg::FQTY_W-1:0]      fill_quantity;
   logic [bbs_pkg::PRICE_IN_W-1:0]  fill_unit_price;
   logic [bbs_pkg::FCOMM_W-1:0]     fill_commission;
   modport source (output valid, command, last_price, bid_price, ask_price, fill_side,
                   fill_quantity, fill_unit_price, fill_commission, input ready);
   modport sink (input valid, command, last_price, bid_price, ask_price, fill_side,
                 fill_quantity, fill_unit_price, fill_commission, output ready);
endinterface

interface bbs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        order_side;
   logic [bbs_pkg::OQTY_W-1:0]  order_quantity;
   modport source (output valid, order_side, order_quantity, input ready);
   modport sink (input valid, order_side, order_quantity, output ready);
endinterface

interface bbs_csr_if;
   logic                       valid;
   logic                       ready;
   logic [bbs_pkg::CFG_W-1:0]  starting_capital;
   modport source (output valid, starting_capital, input ready);
   modport sink (input valid, starting_capital, output ready);
endinterface

// ----- design/bbs_mul.sv -----
// Shared 32x32 multiplier with a registered product.
// Depends on bbs_pkg.
module bbs_mul (
   input  logic                         clock,
   input  bbs_pkg::mul_req_type         mul_req,
   output logic [bbs_pkg::PROD_W-1:0]   prod
);
   logic [bbs_pkg::PROD_W-1:0] prod_ff;
   logic [bbs_pkg::PROD_W-1:0] prod_in;

   assign prod_in = bbs_pkg::PROD_W'(mul_req.a) * bbs_pkg::PROD_W'(mul_req.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

// ----- design/bbs_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on bbs_pkg.
module bbs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bbs_pkg::div_req_type div_req,
   output bbs_pkg::div_rsp_type div_rsp
);
   localparam int CNT_W = $clog2(bbs_pkg::DIV_N);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [bbs_pkg::DIV_D-1:0] rem_ff, rem_in;
   logic [bbs_pkg::DIV_N-1:0] quo_ff, quo_in;
   logic [bbs_pkg::DIV_D-1:0] dsor_ff, dsor_in;
   logic [bbs_pkg::DIV_D:0]   trial;
   logic [bbs_pkg::DIV_D:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[bbs_pkg::DIV_N-1]};
      diff    = trial - {1'b0, dsor_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsor_in = dsor_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsor_in = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsor_ff}) begin
            rem_in = diff[bbs_pkg::DIV_D-1:0];
            quo_in = {quo_ff[bbs_pkg::DIV_N-2:0], 1'b1};
         end else begin
            rem_in = trial[bbs_pkg::DIV_D-1:0];
            quo_in = {quo_ff[bbs_pkg::DIV_N-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(bbs_pkg::DIV_N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsor_ff <= dsor_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule

// ----- design/bbs_core.sv -----
// Sequencer, price window, running sums, position and capital state.
// Depends on bbs_pkg and bbs_if; drives the shared multiplier and divider.
module bbs_core #(
   parameter int WINDOW = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   bbs_req_if.sink                    req,
   bbs_rsp_if.source                  rsp,
   bbs_csr_if.sink                    csr,
   output bbs_pkg::mul_req_type       mul_req,
   input  logic [bbs_pkg::PROD_W-1:0] prod,
   output bbs_pkg::div_req_type       div_req,
   input  bbs_pkg::div_rsp_type       div_rsp
);
   localparam int HW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW = $clog2(WINDOW + 1);
   localparam int SW = bbs_pkg::PRICE_W + $clog2(WINDOW);
   localparam int QW = 2 * bbs_pkg::PRICE_W + $clog2(WINDOW);
   localparam int PW = bbs_pkg::PROD_W;

   typedef enum logic [3:0] {
      S_IDLE, S_PP, S_OO, S_UPD, S_NP, S_SS, S_NQL, S_NQH, S_V, S_DD, S_CMP,
      S_DIV, S_EMIT, S_FMUL, S_FUPD
   } state_type;

   state_type state_ff, state_in;

   logic [bbs_pkg::PRICE_W-1:0] win_mem [WINDOW];
   logic [bbs_pkg::PRICE_W-1:0] old_ff;

   logic [bbs_pkg::PRICE_W-1:0]     p_ff, p_in;
   logic [2*bbs_pkg::PRICE_W-1:0]   pp_ff, pp_in;
   logic [SW-1:0]                   np_ff, np_in;
   logic [PW-1:0]                   ss_ff, ss_in;
   logic [PW-1:0]                   nql_ff, nql_in;
   logic [PW-1:0]                   v4_ff, v4_in;
   logic [SW-1:0]                   d_ff, d_in;
   logic                            gt_ff, gt_in, lt_ff, lt_in;
   logic                            side_ff, side_in;
   logic [bbs_pkg::FQTY_W-1:0]      fqty_ff, fqty_in;
   logic [bbs_pkg::PRICE_IN_W-1:0]  fprice_ff, fprice_in;
   logic [bbs_pkg::FCOMM_W-1:0]     fcomm_ff, fcomm_in;
   logic [HW-1:0]                   head_ff, head_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [SW-1:0]                   sum_ff, sum_in;
   logic [QW-1:0]                   sq_ff, sq_in;
   logic signed [bbs_pkg::POS_W-1:0] pos_ff, pos_in;
   logic signed [bbs_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic                            res_side_ff, res_side_in;
   logic [bbs_pkg::OQTY_W-1:0]      res_qty_ff, res_qty_in;
   logic                            out_valid_ff, out_valid_in;
   logic                            out_side_ff, out_side_in;
   logic [bbs_pkg::OQTY_W-1:0]      out_qty_ff, out_qty_in;

   logic                            req_xfer;
   logic [bbs_pkg::PRICE_W-1:0]     p_new;
   logic                            full_now;
   logic [PW-1:0]                   nq;
   logic                            above, below;
   logic signed [bbs_pkg::POS_W:0]  pos_sum;
   logic signed [bbs_pkg::CAP_W+1:0] delta;
   logic signed [bbs_pkg::CAP_W+1:0] cap_sum;

   assign req_xfer = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = (state_ff == S_IDLE);
   assign full_now = (count_ff == CW'(WINDOW));
   assign p_new = (req.last_price != '0) ? {req.last_price, 1'b0}
                  : bbs_pkg::PRICE_W'(req.bid_price) + bbs_pkg::PRICE_W'(req.ask_price);
   assign nq = {prod[31:0], 32'b0} + nql_ff;
   assign above = gt_ff && (prod > v4_ff);
   assign below = lt_ff && (prod > v4_ff);

   // push the new price and fetch the one it displaces
   always_ff @(posedge clock) begin
      if (req_xfer && req.command == bbs_pkg::CMD_TICK) begin
         win_mem[head_ff] <= p_new;
         old_ff           <= win_mem[head_ff];
      end
   end

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      pp_in        = pp_ff;
      np_in        = np_ff;
      ss_in        = ss_ff;
      nql_in       = nql_ff;
      v4_in        = v4_ff;
      d_in         = d_ff;
      gt_in        = gt_ff;
      lt_in        = lt_ff;
      side_in      = side_ff;
      fqty_in      = fqty_ff;
      fprice_in    = fprice_ff;
      fcomm_in     = fcomm_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      pos_in       = pos_ff;
      cap_in       = cap_ff;
      res_side_in  = res_side_ff;
      res_qty_in   = res_qty_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_side_in  = out_side_ff;
      out_qty_in   = out_qty_ff;
      mul_req      = '0;
      div_req      = '0;
      pos_sum      = '0;
      delta        = '0;
      cap_sum      = '0;

      case (state_ff)
         S_IDLE: begin
            if (csr.valid) begin
               cap_in = bbs_pkg::CAP_W'(csr.starting_capital);
            end
            if (req_xfer) begin
               p_in      = p_new;
               side_in   = req.fill_side;
               fqty_in   = req.fill_quantity;
               fprice_in = req.fill_unit_price;
               fcomm_in  = req.fill_commission;
               state_in  = (req.command == bbs_pkg::CMD_FILL) ? S_FMUL : S_PP;
            end
         end
         S_PP: begin
            mul_req.a = bbs_pkg::MUL_W'(p_ff);
            mul_req.b = bbs_pkg::MUL_W'(p_ff);
            state_in  = S_OO;
         end
         S_OO: begin
            mul_req.a = bbs_pkg::MUL_W'(old_ff);
            mul_req.b = bbs_pkg::MUL_W'(old_ff);
            pp_in     = prod[2*bbs_pkg::PRICE_W-1:0];
            state_in  = S_UPD;
         end
         S_UPD: begin
            if (full_now) begin
               sum_in = sum_ff - SW'(old_ff) + SW'(p_ff);
               sq_in  = sq_ff - QW'(prod) + QW'(pp_ff);
            end else begin
               count_in = count_ff + 1'b1;
               sum_in   = sum_ff + SW'(p_ff);
               sq_in    = sq_ff + QW'(pp_ff);
            end
            head_in  = (head_ff == HW'(WINDOW - 1)) ? '0 : head_ff + 1'b1;
            state_in = (full_now || count_ff == CW'(WINDOW - 1)) ? S_NP : S_IDLE;
         end
         S_NP: begin
            mul_req.a = bbs_pkg::MUL_W'(WINDOW);
            mul_req.b = bbs_pkg::MUL_W'(p_ff);
            state_in  = S_SS;
         end
         S_SS: begin
            mul_req.a = bbs_pkg::MUL_W'(sum_ff);
            mul_req.b = bbs_pkg::MUL_W'(sum_ff);
            np_in     = prod[SW-1:0];
            state_in  = S_NQL;
         end
         S_NQL: begin
            mul_req.a = bbs_pkg::MUL_W'(WINDOW);
            mul_req.b = sq_ff[31:0];
            ss_in     = prod;
            state_in  = S_NQH;
         end
         S_NQH: begin
            mul_req.a = bbs_pkg::MUL_W'(WINDOW);
            mul_req.b = bbs_pkg::MUL_W'(sq_ff[QW-1:32]);
            nql_in    = prod;
            state_in  = S_V;
         end
         S_V: begin
            v4_in = (nq - ss_ff) << 2;
            gt_in = np_ff > sum_ff;
            lt_in = np_ff < sum_ff;
            d_in  = (np_ff > sum_ff) ? np_ff - sum_ff : sum_ff - np_ff;
            state_in = S_DD;
         end
         S_DD: begin
            mul_req.a = bbs_pkg::MUL_W'(d_ff);
            mul_req.b = bbs_pkg::MUL_W'(d_ff);
            state_in  = S_CMP;
         end
         S_CMP: begin
            if (above && pos_ff > 0) begin
               res_side_in = bbs_pkg::SIDE_SELL;
               res_qty_in  = pos_ff[bbs_pkg::OQTY_W-1:0];
               state_in    = S_EMIT;
            end else if (below && pos_ff <= 0 && p_ff != '0 && cap_ff > 0) begin
               div_req.start    = 1'b1;
               div_req.dividend = cap_ff[bbs_pkg::DIV_N-1:0];
               div_req.divisor  = bbs_pkg::DIV_D'({p_ff, 2'b00})
                                  + bbs_pkg::DIV_D'(p_ff);
               state_in         = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               res_side_in = bbs_pkg::SIDE_BUY;
               if (div_rsp.quotient[bbs_pkg::DIV_N-1:bbs_pkg::OQTY_W] != '0) begin
                  res_qty_in = '1;
               end else begin
                  res_qty_in = div_rsp.quotient[bbs_pkg::OQTY_W-1:0];
               end
               state_in = (div_rsp.quotient == '0) ? S_IDLE : S_EMIT;
            end
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               out_side_in  = res_side_ff;
               out_qty_in   = res_qty_ff;
               state_in     = S_IDLE;
            end
         end
         S_FMUL: begin
            mul_req.a = bbs_pkg::MUL_W'(fprice_ff);
            mul_req.b = fqty_ff;
            state_in  = S_FUPD;
         end
         S_FUPD: begin
            if (side_ff == bbs_pkg::SIDE_SELL) begin
               pos_sum = (bbs_pkg::POS_W+1)'(pos_ff) - $signed({17'b0, fqty_ff});
               delta   = $signed({10'b0, prod[55:0]}) - $signed({34'b0, fcomm_ff});
            end else begin
               pos_sum = (bbs_pkg::POS_W+1)'(pos_ff) + $signed({17'b0, fqty_ff});
               delta   = -($signed({10'b0, prod[55:0]}) + $signed({34'b0, fcomm_ff}));
            end
            if (pos_sum > $signed({2'b00, {(bbs_pkg::POS_W-1){1'b1}}})) begin
               pos_in = {1'b0, {(bbs_pkg::POS_W-1){1'b1}}};
            end else if (pos_sum < $signed({2'b11, {(bbs_pkg::POS_W-1){1'b0}}})) begin
               pos_in = {1'b1, {(bbs_pkg::POS_W-1){1'b0}}};
            end else begin
               pos_in = pos_sum[bbs_pkg::POS_W-1:0];
            end
            cap_sum = (bbs_pkg::CAP_W+2)'(cap_ff) + delta;
            if (cap_sum > $signed({3'b000, {(bbs_pkg::CAP_W-1){1'b1}}})) begin
               cap_in = {1'b0, {(bbs_pkg::CAP_W-1){1'b1}}};
            end else if (cap_sum < $signed({3'b111, {(bbs_pkg::CAP_W-1){1'b0}}})) begin
               cap_in = {1'b1, {(bbs_pkg::CAP_W-1){1'b0}}};
            end else begin
               cap_in = cap_sum[bbs_pkg::CAP_W-1:0];
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         pos_ff       <= '0;
         cap_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         pos_ff       <= pos_in;
         cap_ff       <= cap_in;
         out_valid_ff <= out_valid_in;
      end
      p_ff        <= p_in;
      pp_ff       <= pp_in;
      np_ff       <= np_in;
      ss_ff       <= ss_in;
      nql_ff      <= nql_in;
      v4_ff       <= v4_in;
      d_ff        <= d_in;
      gt_ff       <= gt_in;
      lt_ff       <= lt_in;
      side_ff     <= side_in;
      fqty_ff     <= fqty_in;
      fprice_ff   <= fprice_in;
      fcomm_ff    <= fcomm_in;
      res_side_ff <= res_side_in;
      res_qty_ff  <= res_qty_in;
      out_side_ff <= out_side_in;
      out_qty_ff  <= out_qty_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.order_side     = out_side_ff;
   assign rsp.order_quantity = out_qty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(WINDOW)) else $error("window count past depth");
   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= HW'(WINDOW - 1)) else $error("window head out of range");
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.busy |-> state_ff == S_DIV) else $error("divider busy outside wait");
   a_qty_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_qty_ff != '0) else $error("zero order quantity");
endmodule

// ----- design/bollinger_band_signal_top.sv -----
// Top level of the Bollinger band signal block: sequencer core, shared
// multiplier and iterative divider. Depends on bbs_pkg and bbs_if.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   command, prices, fill fields
//   rsp      out  valid/ready   order_side, order_quantity
//   csr      in   valid/ready   starting_capital
//
// A fill updates position and capital; a tick updates the window and, once it is
// full, tests the band and may issue an order; all steps share one registered 32x32
// multiplier. A buy runs the one-bit-per-cycle divider for capital / (5 * price).
// Reset is synchronous; it empties the window and clears position and capital.
// req and csr are ready only between items; a result waits in the output
// register while rsp stalls, and the next item is taken meanwhile.
module bollinger_band_signal_top #(
   parameter int WINDOW = 20
) (
   input  logic        clock,
   input  logic        reset,
   bbs_req_if.sink     req,
   bbs_rsp_if.source   rsp,
   bbs_csr_if.sink     csr
);
   bbs_pkg::mul_req_type       mul_req;
   logic [bbs_pkg::PROD_W-1:0] prod;
   bbs_pkg::div_req_type       div_req;
   bbs_pkg::div_rsp_type       div_rsp;

   bbs_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   bbs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   bbs_core #(.WINDOW(WINDOW)) u_core (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .csr     (csr),
      .mul_req (mul_req),
      .prod    (prod),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );
endmodule

// ----- verif/bollinger_band_signal_top_test.sv -----
// Self-checking testbench for bollinger_band_signal_top.
// Depends on bbs_pkg and the bbs_if interfaces; predicts orders from its own band model.
module bollinger_band_signal_top_test;

   localparam int WIN        = 20;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN      = 100;   // covers a full tick plus the divider
   localparam int PIW        = bbs_pkg::PRICE_IN_W;
   localparam int CFW        = bbs_pkg::CFG_W;
   localparam longint QTY_MAX = 64'h7FFF_FFFF_FFFF;
   localparam longint POS_MAX = 64'h7FFF_FFFF_FFFF;
   localparam longint POS_MIN = -64'sh8000_0000_0000;
   localparam longint CAP_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint CAP_MIN = 64'h8000_0000_0000_0000;
   localparam logic [CFW-1:0] CAP_REG_MAX = '1;

   typedef enum int {EXP_MODEL, EXP_NONE} exp_kind_type;

   typedef struct {
      logic                          command;
      logic [PIW-1:0]                last_price;
      logic [PIW-1:0]                bid_price;
      logic [PIW-1:0]                ask_price;
      logic                          fill_side;
      logic [bbs_pkg::FQTY_W-1:0]    fill_quantity;
      logic [PIW-1:0]                fill_unit_price;
      logic [bbs_pkg::FCOMM_W-1:0]   fill_commission;
   } market_item_type;

   typedef struct {
      logic                       side;
      logic [bbs_pkg::OQTY_W-1:0] quantity;
   } order_type;

   typedef struct {
      int              repeats;
      exp_kind_type    kind;
      market_item_type item;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bbs_req_if req ();
   bbs_rsp_if rsp ();
   bbs_csr_if csr ();

   bollinger_band_signal_top #(.WINDOW(WIN)) DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   always #2 clock = ~clock;

   // band model state
   logic [bbs_pkg::PRICE_W-1:0] price_ring [WIN];
   int                 ring_head;
   int                 ring_fill;
   longint unsigned    price_sum;
   longint unsigned    square_sum;
   longint             position;
   longint             capital;

   order_type pending_orders [$];
   int     mismatches;
   int     tick_count, fill_count, buy_count, sell_count;
   int     idle_cycles;
   bit     no_idle;
   bit     long_hold;
   int     stall_left;
   longint unsigned centre;

   task automatic report_mismatch(input string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic longint add_saturated(input longint a, input longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? CAP_MIN : CAP_MAX;
      return s[63:0];
   endfunction

   function automatic longint clamp_position(input longint v);
      if (v > POS_MAX) return POS_MAX;
      if (v < POS_MIN) return POS_MIN;
      return v;
   endfunction

   // Advance the model by one item; return 1 with the order when one is due.
   function automatic bit predict_order(input market_item_type it, output order_type ord);
      longint unsigned p, old, np, v4, d, q;
      longint qty, value, comm;
      bit above, below;
      ord = '{default: '0};
      if (it.command == bbs_pkg::CMD_FILL) begin
         qty   = it.fill_quantity;
         value = longint'(it.fill_unit_price) * qty;
         comm  = it.fill_commission;
         if (it.fill_side == bbs_pkg::SIDE_SELL) begin
            position = clamp_position(position - qty);
            capital  = add_saturated(capital, value - comm);
         end else begin
            position = clamp_position(position + qty);
            capital  = add_saturated(capital, -(value + comm));
         end
         return 0;
      end
      p = (it.last_price != 0) ? 2 * longint'(it.last_price)
                               : longint'(it.bid_price) + longint'(it.ask_price);
      if (ring_fill >= WIN) begin
         old = price_ring[ring_head];
         price_sum  -= old;
         square_sum -= old * old;
      end else begin
         ring_fill++;
      end
      price_ring[ring_head] = bbs_pkg::PRICE_W'(p);
      price_sum  += p;
      square_sum += p * p;
      ring_head = (ring_head + 1) % WIN;
      if (ring_fill < WIN) return 0;
      np = WIN * p;
      v4 = 4 * (WIN * square_sum - price_sum * price_sum);
      above = 0;
      below = 0;
      if (np > price_sum) begin
         d = np - price_sum;
         above = d * d > v4;
      end else if (np < price_sum) begin
         d = price_sum - np;
         below = d * d > v4;
      end
      if (above && position > 0) begin
         ord.side     = bbs_pkg::SIDE_SELL;
         ord.quantity = bbs_pkg::OQTY_W'(position & QTY_MAX);
         return 1;
      end
      if (below && position <= 0 && p != 0 && capital > 0) begin
         q = longint'(capital) / (5 * p);
         if (q == 0) return 0;
         if (q > QTY_MAX) q = QTY_MAX;
         ord.side     = bbs_pkg::SIDE_BUY;
         ord.quantity = bbs_pkg::OQTY_W'(q);
         return 1;
      end
      return 0;
   endfunction

   function automatic int gap_length();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input market_item_type it, input exp_kind_type kind);
      order_type ord;
      bit        due;
      @(negedge clock);
      req.valid           = 1'b1;
      req.command         = it.command;
      req.last_price      = it.last_price;
      req.bid_price       = it.bid_price;
      req.ask_price       = it.ask_price;
      req.fill_side       = it.fill_side;
      req.fill_quantity   = it.fill_quantity;
      req.fill_unit_price = it.fill_unit_price;
      req.fill_commission = it.fill_commission;
      do @(posedge clock); while (!req.ready);
      due = predict_order(it, ord);
      if (it.command == bbs_pkg::CMD_FILL) fill_count++;
      else tick_count++;
      if (kind == EXP_NONE && due) report_mismatch("typed row expects no order");
      if (due) begin
         pending_orders = {pending_orders, ord};
         if (ord.side == bbs_pkg::SIDE_BUY) buy_count++;
         else sell_count++;
      end
      // hold valid across back-to-back transfers; drop it only for a gap
      repeat (gap_length()) begin
         @(negedge clock);
         req.valid = 1'b0;
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req.valid = 1'b0;
      while (pending_orders.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_capital(input logic [CFW-1:0] value);
      wait_idle();
      @(negedge clock);
      csr.valid            = 1'b1;
      csr.starting_capital = value;
      do @(posedge clock); while (!csr.ready);
      capital = longint'(value);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   function automatic logic [PIW-1:0] near(input longint unsigned c);
      longint unsigned v;
      v = c + $urandom_range(0, 8) - 4;
      if (v == 0) v = 1;
      if (v > 24'hFFFFFF) v = 24'hFFFFFF;
      return PIW'(v);
   endfunction

   function automatic market_item_type random_item();
      market_item_type it;
      int r, s;
      it.command         = bbs_pkg::CMD_TICK;
      it.last_price      = PIW'($urandom);
      it.bid_price       = PIW'($urandom);
      it.ask_price       = PIW'($urandom);
      it.fill_side       = 1'($urandom);
      it.fill_quantity   = $urandom;
      it.fill_unit_price = PIW'($urandom);
      it.fill_commission = $urandom;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         it.command   = bbs_pkg::CMD_FILL;
         it.fill_side = ($urandom_range(0, 9) < 7) ? bbs_pkg::SIDE_BUY : bbs_pkg::SIDE_SELL;
         if ($urandom_range(0, 9) != 0) begin
            it.fill_quantity   = $urandom_range(1, 2000);
            it.fill_unit_price = near(centre);
            it.fill_commission = $urandom_range(0, 50);
         end
      end else if (r < 17) begin
         if ($urandom_range(0, 1)) it.last_price = '0;
      end else begin
         if ($urandom_range(0, 49) == 0) centre = $urandom_range(1, 24'hFFFFFF);
         s = $urandom_range(0, 99);
         if (s < 6) it.last_price = (centre * 3 > 24'hFFFFFF) ? 24'hFFFFFF : PIW'(centre * 3);
         else if (s < 12) it.last_price = (centre / 4 == 0) ? PIW'(1) : PIW'(centre / 4);
         else if (s < 14) it.last_price = PIW'(1);
         else it.last_price = near(centre);
         if ($urandom_range(0, 6) == 0) begin
            it.bid_price  = near(it.last_price);
            it.ask_price  = near(it.last_price);
            it.last_price = '0;
         end
      end
      return it;
   endfunction

   // one row per entry: repeats, check, command, last, bid, ask, side, qty, price, commission
   directed_row_type directed_rows [] = '{
      '{1,  EXP_NONE,  '{bbs_pkg::CMD_FILL, 0, 0, 0, bbs_pkg::SIDE_BUY, 0, 0, 0}},
      '{19, EXP_NONE,  '{bbs_pkg::CMD_TICK, 1000, 5, 7, bbs_pkg::SIDE_BUY, 0, 0, 0}},
      '{1,  EXP_MODEL, '{bbs_pkg::CMD_TICK, 0, 999, 1001, bbs_pkg::SIDE_SELL, 0, 0, 0}},
      '{1,  EXP_MODEL, '{bbs_pkg::CMD_TICK, 0, 0, 0, bbs_pkg::SIDE_BUY, 0, 0, 0}},
      '{1,  EXP_MODEL, '{bbs_pkg::CMD_TICK, 1, 0, 0, bbs_pkg::SIDE_BUY, 0, 0, 0}},
      '{1,  EXP_NONE,  '{bbs_pkg::CMD_FILL, 0, 0, 0, bbs_pkg::SIDE_BUY, 5, 1, 0}},
      '{1,  EXP_MODEL, '{bbs_pkg::CMD_TICK, 24'hFFFFFF, 0, 0, bbs_pkg::SIDE_BUY, 0, 0, 0}},
      '{1,  EXP_NONE,  '{bbs_pkg::CMD_FILL, 0, 0, 0, bbs_pkg::SIDE_SELL, '1, 24'hFFFFFF, '1}},
      '{1,  EXP_NONE,  '{bbs_pkg::CMD_FILL, 0, 0, 0, bbs_pkg::SIDE_BUY, '1, 24'hFFFFFF, '1}},
      '{1,  EXP_MODEL, '{bbs_pkg::CMD_TICK, 0, 24'hFFFFFF, 24'hFFFFFF, bbs_pkg::SIDE_BUY,
                         0, 0, 0}},
      '{1,  EXP_MODEL, '{bbs_pkg::CMD_TICK, 1, 24'hFFFFFF, 0, bbs_pkg::SIDE_SELL,
                         '1, '1, '1}}
   };

   // result side: compare each transfer with the oldest expected order
   always @(posedge clock) begin
      order_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_orders.size() == 0) begin
            report_mismatch("order with none expected");
         end else begin
            want = pending_orders[0];
            pending_orders.delete(0);
            if (rsp.order_side !== want.side)
               report_mismatch($sformatf("side %0b, want %0b", rsp.order_side, want.side));
            if (rsp.order_quantity !== want.quantity)
               report_mismatch($sformatf("quantity %0d, want %0d",
                                         rsp.order_quantity, want.quantity));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver stalls, with one long hold on request
   initial begin
      rsp.ready  = 1'b0;
      stall_left = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (long_hold) begin
            long_hold  = 1'b0;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            rsp.ready = 1'b0;
            stall_left--;
         end else begin
            rsp.ready  = 1'b1;
            stall_left = gap_length();
         end
      end
   end

   initial begin
      logic [CFW-1:0] settings [4];
      req.valid = 1'b0;
      req.command = bbs_pkg::CMD_TICK;
      req.last_price = '0;
      req.bid_price = '0;
      req.ask_price = '0;
      req.fill_side = bbs_pkg::SIDE_BUY;
      req.fill_quantity = '0;
      req.fill_unit_price = '0;
      req.fill_commission = '0;
      csr.valid = 1'b0;
      csr.starting_capital = '0;
      idle_cycles = 0;
      mismatches = 0;
      no_idle = 1'b0;
      long_hold = 1'b0;
      ring_head = 0;
      ring_fill = 0;
      price_sum = 0;
      square_sum = 0;
      position = 0;
      capital = 0;
      centre = 5000;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_capital(CFW'(1000000));
      foreach (directed_rows[i])
         repeat (directed_rows[i].repeats) send_item(directed_rows[i].item, directed_rows[i].kind);

      settings[0] = '0;
      settings[1] = CAP_REG_MAX;
      settings[2] = CFW'($urandom_range(1, 100000));
      settings[3] = CFW'({$urandom, $urandom});
      for (int ph = 0; ph < 4; ph++) begin
         write_capital(settings[ph]);
         no_idle = (ph == 1);
         if (ph == 2) long_hold = 1'b1;
         repeat (250) send_item(random_item(), EXP_MODEL);
      end
      no_idle = 1'b0;
      write_capital(CFW'($urandom_range(1, 1000)));
      repeat (30) send_item(random_item(), EXP_MODEL);

      wait_idle();
      $display("tb: %0d ticks and %0d fills sent under 6 capital settings",
               tick_count, fill_count);
      $display("tb: %0d buy and %0d sell orders checked, %0d mismatches",
               buy_count, sell_count, mismatches);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
design/bbs_pkg.sv
design/bbs_if.sv
design/bbs_mul.sv
design/bbs_div.sv
design/bbs_core.sv
design/bollinger_band_signal_top.sv
verif/bollinger_band_signal_top_test.sv
